// File: hdl/bppc_pkg.sv
// Shared types and constants for the bitplane pixel plot cache.
// No dependencies; imported by bitplane_pixel_plot_cache, bppc_checker and the testbench.
package bppc_pkg;

  // command word: plot a pixel or flush the cached rows
  typedef struct packed {
    logic       mode;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] color;
  } cmd_word_t;

  // bitplane byte write word
  typedef struct packed {
    logic [23:0] address;
    logic [7:0]  data;
    logic [7:0]  bit_mask;
    logic        last;
  } wr_word_t;

  localparam logic MODE_PLOT  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // register indexes (word address)
  localparam logic [1:0] REG_FLAGS  = 2'd0;
  localparam logic [1:0] REG_DEPTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_BASE   = 2'd3;

  // flag bits
  localparam int FLAG_TRANSP = 0;
  localparam int FLAG_DITHER = 1;
  localparam int FLAG_FREEZE = 3;
  localparam int FLAG_SPRITE = 4;

  localparam logic [1:0] DEPTH_8BPP    = 2'd3;
  localparam logic [1:0] LAYOUT_SPRITE = 2'd3;
  localparam logic [1:0] LAYOUT_1      = 2'd1;
  localparam logic [1:0] LAYOUT_2      = 2'd2;

  // frame buffer bank, bits 23:20 of the address
  localparam logic [3:0] BANK_HI = 4'h7;

endpackage

// File: hdl/bitplane_pixel_plot_cache.sv
// Bitplane pixel plot cache: two-entry 8-pixel row cache, masked plane byte writer.
// Depends on bppc_pkg.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes plot or flush words. A plot
//   passes the transparency test and dither, then lands in the newest cached
//   row. A row change or a full row writes the older row out; a flush writes
//   out the older then the newer row and clears both.
//   wr channel (wr_valid/wr_ready/wr) gives one masked bitplane byte write
//   per plane (2, 4 or 8 planes); last marks the final write of a command. The user
//   must write registers over the APB port only while idle; the block does not enforce it.
// Sequence:
//   A command with no write leaves cmd_ready high. A row write runs through
//   one shared 20-bit adder: S_A0, S_A1 and S_A2 build the row address, then
//   S_WR adds one plane offset per word loaded, waiting while wr stalls;
//   cmd_ready stays low until the last plane is loaded. A flush of two rows
//   runs S_A0 to S_WR once per row before cmd_ready rises.
// Reset: both rows empty, registers cleared, no word pending.
// Stall: a word held on wr waits in the output register; the plane counter
//   waits with it. The next command is taken while the last word waits.
module bitplane_pixel_plot_cache (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  bppc_pkg::cmd_word_t   cmd,
  output logic                  wr_valid,
  input  logic                  wr_ready,
  output bppc_pkg::wr_word_t    wr,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import bppc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_A0   = 3'd1;
  localparam logic [2:0] S_A1   = 3'd2;
  localparam logic [2:0] S_A2   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;

  logic [2:0]  state;
  logic [4:0]  flags;
  logic [1:0]  depth;
  logic [1:0]  height;
  logic [7:0]  base;

  logic        new_real;
  logic [12:0] new_idx;
  logic [7:0]  new_pend;
  logic [7:0]  new_pix [8];
  logic [12:0] old_idx;
  logic [7:0]  old_pend;
  logic [7:0]  old_pix [8];

  logic [12:0] w_idx;
  logic [7:0]  w_pend;
  logic [7:0]  w_pix [8];
  logic        second;
  logic [7:0]  f_pend;
  logic [2:0]  plane;
  logic [19:0] acc;

  // APB
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_FLAGS:  prdata = {27'd0, flags};
      REG_DEPTH:  prdata = {30'd0, depth};
      REG_HEIGHT: prdata = {30'd0, height};
      REG_BASE:   prdata = {24'd0, base};
      default:    prdata = '0;
    endcase
  end

  // command decode
  logic       cmd_fire, transp, plot_go, flush_go, match, full, age;
  logic [7:0] colr;
  logic [12:0] idx;
  logic [2:0] bitpos;
  logic [7:0] bitmask, np;
  logic [7:0] pix_upd [8];

  assign cmd_ready = (state == S_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign idx       = {cmd.pos_y, cmd.pos_x[7:3]};
  assign bitpos    = ~cmd.pos_x[2:0];
  assign bitmask   = 8'd1 << bitpos;

  always_comb begin
    transp = 1'b0;
    if (!flags[FLAG_TRANSP]) begin
      if (depth == DEPTH_8BPP) begin
        if (flags[FLAG_FREEZE]) transp = (cmd.color[3:0] == 4'd0);
        else transp = (cmd.color == 8'd0);
      end else begin
        transp = (cmd.color[3:0] == 4'd0);
      end
    end
    colr = cmd.color;
    if (flags[FLAG_DITHER] && depth != DEPTH_8BPP) begin
      if (cmd.pos_x[0] ^ cmd.pos_y[0]) colr = {4'd0, cmd.color[7:4]};
      else colr = {4'd0, cmd.color[3:0]};
    end
    for (int i = 0; i < 8; i++) begin
      pix_upd[i] = (i[2:0] == bitpos) ? colr : new_pix[i];
    end
  end

  assign plot_go  = cmd_fire && (cmd.mode == MODE_PLOT) && !transp;
  assign flush_go = cmd_fire && (cmd.mode == MODE_FLUSH);
  assign match    = new_real && (new_idx == idx);
  assign np       = new_pend | bitmask;
  assign full     = match && (np == 8'hff);
  assign age      = plot_go && (!match || full);

  // write engine
  logic [1:0]  layout;
  logic [2:0]  planes_m1;
  logic [7:0]  xf, yr;
  logic [19:0] opa, opb, sum;
  logic        load_out, plane_end;
  logic [7:0]  pdata;

  assign layout    = flags[FLAG_SPRITE] ? LAYOUT_SPRITE : height;
  assign planes_m1 = (depth == 2'd0) ? 3'd1 : (depth == DEPTH_8BPP) ? 3'd7 : 3'd3;
  assign xf        = {w_idx[4:0], 3'b000};
  assign yr        = w_idx[12:5];
  assign load_out  = (state == S_WR) && (!wr_valid || wr_ready);
  assign plane_end = (plane == planes_m1);

  always_comb begin
    opa = '0;
    opb = '0;
    case (state)
      S_A0: begin
        if (layout == LAYOUT_SPRITE) begin
          opa = {10'd0, yr[7], xf[7], yr[6:3], xf[6:3]};
        end else begin
          opa = {11'd0, xf, 1'b0};
          if (layout == LAYOUT_1) opb = {13'd0, xf[7:1]};
          else if (layout == LAYOUT_2) opb = {12'd0, xf};
        end
      end
      S_A1: begin
        opa = acc;
        if (layout != LAYOUT_SPRITE) opb = {15'd0, yr[7:3]};
      end
      S_A2: begin
        opa = acc << (3'd4 + {2'd0, planes_m1[1]} + {2'd0, planes_m1[2]});
        opb = {2'd0, base, 6'd0, yr[2:0], 1'b0};
      end
      S_WR: begin
        opa = acc;
        opb = {14'd0, plane[2:1], 3'b000, plane[0]};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    sum = opa + opb;
    for (int p = 0; p < 8; p++) begin
      pdata[p] = w_pix[p][plane] & w_pend[p];
    end
  end

  // row to load into the write engine
  logic       w_load;
  logic [1:0] w_src;
  localparam logic [1:0] SRC_OLD  = 2'd0;
  localparam logic [1:0] SRC_NEW  = 2'd1;
  localparam logic [1:0] SRC_HELD = 2'd2;

  always_comb begin
    w_load = 1'b0;
    w_src  = SRC_OLD;
    if (age && old_pend != 8'd0) begin
      w_load = 1'b1;
    end else if (flush_go) begin
      if (old_pend != 8'd0) begin
        w_load = 1'b1;
      end else if (new_pend != 8'd0) begin
        w_load = 1'b1;
        w_src  = SRC_NEW;
      end
    end else if (load_out && plane_end && second) begin
      w_load = 1'b1;
      w_src  = SRC_HELD;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      flags    <= '0;
      depth    <= '0;
      height   <= '0;
      base     <= '0;
      new_real <= 1'b0;
      new_pend <= '0;
      old_pend <= '0;
      second   <= 1'b0;
      plane    <= '0;
      wr_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_FLAGS:  flags  <= pwdata[4:0];
          REG_DEPTH:  depth  <= pwdata[1:0];
          REG_HEIGHT: height <= pwdata[1:0];
          REG_BASE:   base   <= pwdata[7:0];
          default:    flags  <= flags;
        endcase
      end
      if (plot_go) begin
        if (!match) begin
          old_pend <= new_pend;
          new_pend <= bitmask;
          new_real <= 1'b1;
        end else if (full) begin
          old_pend <= 8'hff;
          new_pend <= '0;
        end else begin
          new_pend <= np;
        end
      end
      if (flush_go) begin
        old_pend <= '0;
        new_pend <= '0;
        second   <= (old_pend != 8'd0) && (new_pend != 8'd0);
      end
      if (load_out) wr_valid <= 1'b1;
      else if (wr_valid && wr_ready) wr_valid <= 1'b0;
      case (state)
        S_IDLE: if (w_load) state <= S_A0;
        S_A0:   state <= S_A1;
        S_A1:   state <= S_A2;
        S_A2: begin
          state <= S_WR;
          plane <= '0;
        end
        S_WR: begin
          if (load_out) begin
            plane <= plane + 3'd1;
            if (plane_end) begin
              if (second) begin
                second <= 1'b0;
                state  <= S_A0;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (plot_go) begin
      new_pix <= pix_upd;
      if (age) begin
        old_idx <= new_idx;
        old_pix <= match ? pix_upd : new_pix;
      end
      if (!match) new_idx <= idx;
    end
    if (flush_go) f_pend <= new_pend;
    if (w_load) begin
      case (w_src)
        SRC_OLD: begin
          w_idx  <= old_idx;
          w_pend <= old_pend;
          w_pix  <= old_pix;
        end
        SRC_NEW: begin
          w_idx  <= new_idx;
          w_pend <= new_pend;
          w_pix  <= new_pix;
        end
        default: begin
          w_idx  <= new_idx;
          w_pend <= f_pend;
          w_pix  <= new_pix;
        end
      endcase
    end
    if (state == S_A0 || state == S_A1 || state == S_A2) acc <= sum;
    if (load_out) begin
      wr.address  <= {BANK_HI, sum};
      wr.data     <= pdata;
      wr.bit_mask <= w_pend;
      wr.last     <= plane_end && !second;
    end
  end

`ifndef SYNTHESIS
  a_full_row_aged: assert property (@(posedge clk) disable iff (rst)
    new_pend != 8'hff) else $error("newest row left full");
  a_job_not_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_A0 |-> w_pend != 8'd0) else $error("row write with empty mask");
  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |-> plane <= planes_m1) else $error("plane counter out of range");
  a_second_held: assert property (@(posedge clk) disable iff (rst)
    second |-> f_pend != 8'd0) else $error("second row queued with empty mask");
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    wr_valid && !wr.last |-> state != S_IDLE) else $error("idle before final write");
`endif

endmodule

// File: dv/bppc_checker.sv
// Scoreboard for the bitplane pixel plot cache: snoops cmd, wr and APB writes,
// keeps its own copy of the registers and the two-row cache, and checks each plane write.
// Depends on bppc_pkg.
`timescale 1ns / 1ps
module bppc_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic                cmd_ready,
  input  bppc_pkg::cmd_word_t cmd,
  input  logic                wr_valid,
  input  logic                wr_ready,
  input  bppc_pkg::wr_word_t  wr,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  errors,
  output int                  backlog,
  output int                  words_seen
);
  import bppc_pkg::*;

  logic [4:0]       opt_flags;
  logic [1:0]       depth_sel;
  logic [1:0]       height_sel;
  logic [7:0]       base_kb;

  logic [15:0]      newer_idx, older_idx;
  logic [7:0]       newer_mask, older_mask;
  logic [7:0][7:0]  newer_px, older_px;

  wr_word_t         plane_writes_due[$];
  wr_word_t         want_w;

  function automatic int plane_count();
    if (depth_sel == DEPTH_8BPP) return 8;
    return (depth_sel == '0) ? 2 : 4;
  endfunction

  function automatic logic [23:0] row_addr(input logic [7:0] x, input logic [7:0] y);
    int unsigned xs, ys, tile, sum;
    logic [1:0]  layout;
    xs = x;
    ys = y;
    layout = opt_flags[FLAG_SPRITE] ? LAYOUT_SPRITE : height_sel;
    case (layout)
      LAYOUT_1: tile = ((xs & 'hf8) << 1) + ((xs & 'hf8) >> 1) + ((ys & 'hf8) >> 3);
      LAYOUT_2: tile = ((xs & 'hf8) << 1) + (xs & 'hf8) + ((ys & 'hf8) >> 3);
      LAYOUT_SPRITE: tile = ((ys & 'h80) << 2) + ((xs & 'h80) << 1) + ((ys & 'h78) << 1)
                            + ((xs & 'h78) >> 3);
      default: tile = ((xs & 'hf8) << 1) + ((ys & 'hf8) >> 3);
    endcase
    sum = 32'h700000 + tile * (plane_count() * 8) + (int'(base_kb) << 10) + (ys & 7) * 2;
    return sum[23:0];
  endfunction

  function automatic logic is_clear(input logic [7:0] colr);
    if (opt_flags[FLAG_TRANSP]) return 1'b0;
    if (depth_sel == DEPTH_8BPP)
      return opt_flags[FLAG_FREEZE] ? (colr[3:0] == 4'h0) : (colr == 8'h00);
    return colr[3:0] == 4'h0;
  endfunction

  task automatic write_row(input logic [15:0] idx, input logic [7:0] mask,
                           input logic [7:0][7:0] px);
    logic [23:0] base;
    logic [7:0]  bits;
    wr_word_t    w;
    if (mask == 8'h00) return;
    base = row_addr({idx[4:0], 3'b000}, idx[12:5]);
    for (int n = 0; n < plane_count(); n++) begin
      for (int p = 0; p < 8; p++) bits[p] = px[p][n];
      w.address  = base + 24'(((n >> 1) << 4) + (n & 1));
      w.data     = bits & mask;
      w.bit_mask = mask;
      w.last     = 1'b0;
      plane_writes_due.push_back(w);
    end
  endtask

  task automatic age_rows();
    older_idx  = newer_idx;
    older_mask = newer_mask;
    older_px   = newer_px;
    newer_mask = 8'h00;
  endtask

  task automatic predict_plot(input cmd_word_t c);
    int          start;
    logic [7:0]  colr;
    logic [15:0] idx;
    logic [2:0]  slot;
    wr_word_t    w;
    start = plane_writes_due.size();
    if (c.mode == MODE_FLUSH) begin
      write_row(older_idx, older_mask, older_px);
      write_row(newer_idx, newer_mask, newer_px);
      older_mask = 8'h00;
      newer_mask = 8'h00;
    end else if (!is_clear(c.color)) begin
      colr = c.color;
      if (opt_flags[FLAG_DITHER] && depth_sel != DEPTH_8BPP)
        colr = ((c.pos_x[0] ^ c.pos_y[0]) ? (colr >> 4) : colr) & 8'h0f;
      idx = {3'b000, c.pos_y, c.pos_x[7:3]};
      if (idx != newer_idx) begin
        write_row(older_idx, older_mask, older_px);
        age_rows();
        newer_idx = idx;
      end
      slot = ~c.pos_x[2:0];
      newer_px[slot]   = colr;
      newer_mask[slot] = 1'b1;
      if (newer_mask == 8'hff) begin
        write_row(older_idx, older_mask, older_px);
        age_rows();
      end
    end
    if (plane_writes_due.size() > start) begin
      w = plane_writes_due[plane_writes_due.size() - 1];
      w.last = 1'b1;
      plane_writes_due[plane_writes_due.size() - 1] = w;
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (errors < 60)
      $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      opt_flags  = '0;
      depth_sel  = '0;
      height_sel = '0;
      base_kb    = '0;
      newer_idx  = 16'hffff;
      older_idx  = 16'hffff;
      newer_mask = '0;
      older_mask = '0;
      newer_px   = '0;
      older_px   = '0;
      plane_writes_due.delete();
      errors     = 0;
      words_seen = 0;
    end else begin
      if (wr_valid && wr_ready) begin
        words_seen++;
        if (plane_writes_due.size() == 0) begin
          report("unexpected word, address", 32'(wr.address), 32'h0);
        end else begin
          want_w = plane_writes_due.pop_front();
          if (wr.address != want_w.address) report("address", 32'(wr.address), 32'(want_w.address));
          if (wr.data != want_w.data) report("data", 32'(wr.data), 32'(want_w.data));
          if (wr.bit_mask != want_w.bit_mask)
            report("bit_mask", 32'(wr.bit_mask), 32'(want_w.bit_mask));
          if (wr.last != want_w.last) report("last", 32'(wr.last), 32'(want_w.last));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FLAGS:  opt_flags  = pwdata[4:0];
          REG_DEPTH:  depth_sel  = pwdata[1:0];
          REG_HEIGHT: height_sel = pwdata[1:0];
          REG_BASE:   base_kb    = pwdata[7:0];
          default: ;
        endcase
      end
      if (cmd_valid && cmd_ready) predict_plot(cmd);
    end
    backlog <= plane_writes_due.size();
  end

endmodule

// File: dv/tb_bitplane_pixel_plot_cache.sv
// Testbench top for bitplane_pixel_plot_cache: clock, reset, APB set-up,
// plot/flush stimulus with random stalls, and the verdict. Uses bppc_pkg and bppc_checker.
`timescale 1ns / 1ps
module tb_bitplane_pixel_plot_cache;
  import bppc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 24;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 51;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_ready;
  cmd_word_t  cmd = '0;
  logic       wr_valid;
  logic       wr_ready = 1'b0;
  wr_word_t   wr;
  logic       psel = 1'b0;
  logic       penable = 1'b0;
  logic       pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic       pready;

  int   errors, backlog, words_seen;
  int   items_sent = 0;
  int   settings = 0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  logic calm = 1'b0;
  logic [7:0] prev_y = '0, prev_xg = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitplane_pixel_plot_cache uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .wr_valid(wr_valid), .wr_ready(wr_ready), .wr(wr),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bppc_checker chk (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .wr_valid(wr_valid), .wr_ready(wr_ready), .wr(wr),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .backlog(backlog), .words_seen(words_seen)
  );

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      wr_ready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      wr_ready   <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      wr_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (wr_valid && wr_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(input logic m, input logic [7:0] x, input logic [7:0] y,
                      input logic [7:0] c);
    cmd_word_t w;
    int        gap;
    w.mode  = m;
    w.pos_x = x;
    w.pos_y = y;
    w.color = c;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd       <= w;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    items_sent++;
  endtask

  task automatic plot(input logic [7:0] x, input logic [7:0] y, input logic [7:0] c);
    send(MODE_PLOT, x, y, c);
  endtask

  task automatic flush();
    send(MODE_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // hold off until every plane write is out and the block has gone quiet
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [4:0] flags, input logic [1:0] depth,
                           input logic [1:0] height, input logic [7:0] base);
    reg_write(REG_FLAGS, 32'(flags));
    reg_write(REG_DEPTH, 32'(depth));
    reg_write(REG_HEIGHT, 32'(height));
    reg_write(REG_BASE, 32'(base));
    settings++;
  endtask

  function automatic logic [7:0] pick_color();
    if ($urandom_range(0, 7) == 0)
      return $urandom_range(0, 1) ? 8'h00 : {4'($urandom_range(0, 15)), 4'h0};
    return 8'($urandom);
  endfunction

  // mostly row-local runs, some full rows, some scattered plots and flushes
  task automatic random_burst();
    int         kind;
    int         len;
    logic [7:0] y;
    logic [7:0] xg;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) begin
      y  = prev_y;
      xg = prev_xg;
    end else begin
      y  = 8'($urandom);
      xg = {5'($urandom), 3'b000};
    end
    prev_y  = y;
    prev_xg = xg;
    if (kind == 0) begin
      flush();
    end else if (kind <= 2) begin
      plot(8'($urandom), 8'($urandom), pick_color());
    end else if (kind <= 5) begin
      for (int i = 0; i < 8; i++) plot(xg + 8'(i), y, pick_color());
      if ($urandom_range(0, 1) == 1) plot(xg + 8'($urandom_range(0, 7)), y, pick_color());
    end else begin
      len = $urandom_range(2, 6);
      for (int i = 0; i < len; i++) plot(xg + 8'($urandom_range(0, 7)), y, pick_color());
    end
  endtask

  initial begin
    int target;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 2 bpp, layout 0: empty flush, transparent colours, row change, full row
    configure(5'h00, 2'd0, 2'd0, 8'h00);
    flush();
    plot(8'd0, 8'd0, 8'h00);
    plot(8'd0, 8'd0, 8'h10);
    plot(8'd0, 8'd0, 8'hff);
    plot(8'd7, 8'd0, 8'h01);
    plot(8'd8, 8'd0, 8'h02);
    plot(8'd255, 8'd255, 8'haa);
    for (int i = 0; i < 8; i++) plot(8'(16 + i), 8'd3, 8'(i + 1));
    flush();

    // every flag, 8 bpp, sprite layout, top base
    drain();
    configure(5'h1f, DEPTH_8BPP, LAYOUT_SPRITE, 8'hff);
    plot(8'd0, 8'd0, 8'h00);
    plot(8'd255, 8'd255, 8'hff);
    plot(8'd128, 8'd128, 8'h80);
    flush();

    // dither at 4 bpp
    drain();
    configure(5'h02, 2'd1, LAYOUT_1, 8'h80);
    plot(8'd1, 8'd0, 8'h5a);
    plot(8'd2, 8'd0, 8'ha5);
    plot(8'd3, 8'd3, 8'h3c);
    flush();

    // freeze high at 8 bpp: only the low nibble decides transparency
    drain();
    configure(5'h08, DEPTH_8BPP, LAYOUT_2, 8'h01);
    plot(8'd5, 8'd5, 8'h10);
    plot(8'd5, 8'd5, 8'h01);
    flush();

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == 0)
        configure(5'h00, 2'd0, 2'd0, 8'h00);
      else if (p == 1)
        configure(5'h1f, DEPTH_8BPP, LAYOUT_SPRITE, 8'hff);
      else
        configure(5'($urandom), 2'($urandom), 2'($urandom), 8'($urandom));
      if (p == PHASES - 1) calm = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_burst();
    end
    drain();

    $display("run: %0d commands, %0d plane writes, %0d register settings", items_sent,
             words_seen, settings);
    $display("run: 2/4/8 planes, all tile layouts, dither, transparency and freeze on and off");
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
hdl/bppc_pkg.sv
hdl/bitplane_pixel_plot_cache.sv
dv/bppc_checker.sv
dv/tb_bitplane_pixel_plot_cache.sv
